/* sv/edit_transaction_translation_parser_assert.svh */
// Assertion macros for the edit transaction parser checker.
`ifndef EDIT_TRANSACTION_TRANSLATION_PARSER_ASSERT_SVH
`define EDIT_TRANSACTION_TRANSLATION_PARSER_ASSERT_SVH

// Condition that holds on every clock edge outside reset.
`define ETTP_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked on the following edge.
`define ETTP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold on the edge after reset is sampled low.
`define ETTP_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

/* sv/ettp_pkg.sv */
`timescale 1ns / 1ps
package ettp_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  localparam logic KIND_DELTA  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_MALFORMED = 2'd1;
  localparam logic [1:0] STAT_ACTOR     = 2'd2;
  localparam logic [1:0] STAT_UNSUP     = 2'd3;

  localparam logic [7:0] OP_CREATE   = 8'd0;
  localparam logic [7:0] OP_REPARENT = 8'd3;
  localparam logic [7:0] OP_COMP_ADD = 8'd4;
  localparam logic [7:0] OP_COMP_DEL = 8'd5;
  localparam logic [7:0] OP_SET      = 8'd6;

  localparam logic [7:0] VTAG_VEC3 = 8'd6;

  typedef struct packed {
    logic        kind;
    logic [63:0] node_id;
    logic [31:0] delta_x;
    logic [31:0] delta_y;
    logic [31:0] delta_z;
    logic [1:0]  status;
    logic [31:0] op_count;
  } ettp_res_t;

  typedef enum logic [1:0] {
    PL_FIXED,
    PL_LENGTH,
    PL_UNKNOWN
  } ettp_plkind_t;

  // Payload size of a value tag.
  function automatic logic [4:0] vtag_bytes(input logic [7:0] tag);
    case (tag) inside
      8'd1: return 5'd1;
      8'd2, 8'd4, 8'd5, 8'd11: return 5'd8;
      8'd3: return 5'd4;
      8'd6: return 5'd12;
      8'd7, 8'd8: return 5'd16;
      default: return 5'd0;
    endcase
  endfunction

  function automatic ettp_plkind_t vtag_kind(input logic [7:0] tag);
    if (tag == 8'd9 || tag == 8'd10) return PL_LENGTH;
    if (tag > 8'd11) return PL_UNKNOWN;
    return PL_FIXED;
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  // binary32 a - b, round to nearest even, any NaN gives the canonical quiet NaN.
  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] bn, x, y;
    logic        sx, sy, up, found;
    logic [7:0]  ex, ey, d, shl, lz;
    logic [23:0] mx, my;
    logic [49:0] w;
    logic [26:0] ys, n;
    logic [27:0] s;
    logic [8:0]  e;
    logic [30:0] mag;
    bn = b ^ 32'h8000_0000;
    if (is_nan(a) || is_nan(b)) return QNAN_BITS;
    if (a[30:0] == 31'h7F80_0000 && bn[30:0] == 31'h7F80_0000)
      return (a[31] != bn[31]) ? QNAN_BITS : a;
    if (a[30:0] == 31'h7F80_0000) return a;
    if (bn[30:0] == 31'h7F80_0000) return bn;
    if (a[30:0] >= bn[30:0]) begin
      x = a;
      y = bn;
    end else begin
      x = bn;
      y = a;
    end
    sx = x[31];
    sy = y[31];
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {y[30:23] != 8'd0, y[22:0]};
    d = ex - ey;
    w = {my, 26'd0} >> d;
    if (d >= 8'd27) ys = {26'd0, |my};
    else ys = {w[49:24], w[23] | (|w[22:0])};
    if (sx == sy) s = {1'b0, mx, 3'b000} + {1'b0, ys};
    else s = {1'b0, mx, 3'b000} - {1'b0, ys};
    if (s == 28'd0) return {(sx == sy) ? sx : 1'b0, 31'd0};
    if (s[27]) begin
      n = {s[27:2], s[1] | s[0]};
      e = {1'b0, ex} + 9'd1;
    end else begin
      lz = 8'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found && s[i]) found = 1'b1;
        else if (!found) lz = lz + 8'd1;
      end
      shl = (lz < ex) ? lz : ex - 8'd1;
      n = s[26:0] << shl;
      e = {1'b0, ex - shl};
      if (!n[26]) e = 9'd0;
    end
    if (e >= 9'd255) return {sx, 8'hFF, 23'd0};
    up = n[2] & (n[1] | n[0] | n[3]);
    mag = {e[7:0], n[25:3]} + {30'd0, up};
    return {sx, mag};
  endfunction

endpackage

/* sv/ettp_if.sv */
`timescale 1ns / 1ps
interface ettp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, data_byte, is_last, input ready);
  modport sink (input valid, data_byte, is_last, output ready);
endinterface

interface ettp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] node_id;
  logic [31:0] delta_x;
  logic [31:0] delta_y;
  logic [31:0] delta_z;
  logic [1:0]  status;
  logic [31:0] op_count;

  modport source (output valid, kind, node_id, delta_x, delta_y, delta_z, status, op_count,
                  input ready);
  modport sink (input valid, kind, node_id, delta_x, delta_y, delta_z, status, op_count,
                output ready);
endinterface

/* sv/edit_transaction_translation_parser.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   data_byte[7:0], is_last
// out_ch    out  kind, node_id[63:0], delta_x/y/z[31:0], status[1:0], op_count[31:0]
//
// One byte beat per cycle while in_ch.ready is high; the parser state and the lane
// subtractor settle in the cycle the beat is taken, and its zero, one or two
// results land in a 4-entry result queue. in_ch.ready is high while the queue
// has at least two free entries, so a stalled output stops input before it fills.
// Synchronous active-low reset returns the parser to the transaction identity field.
module edit_transaction_translation_parser (
  input  logic       clk,
  input  logic       rst_n,
  ettp_in_if.sink    in_ch,
  ettp_out_if.source out_ch
);
  import ettp_pkg::*;

  typedef enum logic [4:0] {
    S_TXID, S_DOC, S_NAME_LEN, S_NAME_BODY, S_ACTOR, S_ACTOR_LEN, S_ACTOR_BODY,
    S_HASKEY, S_KEY_LEN, S_KEY_BODY, S_OPCOUNT, S_OPTAG, S_SF_NODE, S_SF_SKIP,
    S_SF_VTAG, S_SF_VSKIP, S_SF_VLEN, S_SF_VLANES, S_CO_SKIP, S_CO_COUNT,
    S_CO_FKEY, S_CO_VTAG, S_CO_VLEN, S_CO_VSKIP, S_CN_SKIP, S_CN_HASP,
    S_CN_PSKIP, S_RP_SKIP, S_RP_HASP, S_RP_PSKIP, S_DONE, S_ERR
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] bc_r, bc_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [31:0] opsr_r, opsr_nxt;
  logic [31:0] opst_r, opst_nxt;
  logic [31:0] fr_r, fr_nxt;
  logic [1:0]  sr_r, sr_nxt;
  logic [63:0] nl_r, nl_nxt;
  logic [31:0] lanes_r [3];
  logic [31:0] lanes_nxt [3];
  logic [3:0]  vf_r, vf_nxt;
  logic [1:0]  ec_r, ec_nxt;

  ettp_res_t   q_r [4];
  logic [2:0]  cnt_r;
  logic [1:0]  wp_r, rp_r;

  logic        acc, pop;
  logic        emit_d, emit_s;
  ettp_res_t   res_d, res_s;

  // helper temporaries
  logic [31:0] bc_dec, op_dec, fr_dec;
  logic [7:0]  v1;
  logic [31:0] v4, lane_bits;
  logic [1:0]  lane, sr_dec, stat;
  logic        vec3, value_end;
  ettp_plkind_t pk;

  assign acc = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r <= 3'd2);

  always_comb begin
    state_nxt = state_r;
    bc_nxt    = bc_r;
    sh_nxt    = sh_r;
    opsr_nxt  = opsr_r;
    opst_nxt  = opst_r;
    fr_nxt    = fr_r;
    sr_nxt    = sr_r;
    nl_nxt    = nl_r;
    lanes_nxt = lanes_r;
    vf_nxt    = vf_r;
    ec_nxt    = ec_r;
    emit_d    = 1'b0;
    emit_s    = 1'b0;
    bc_dec    = (bc_r != 32'd0) ? bc_r - 32'd1 : 32'd0;
    op_dec    = opsr_r - 32'd1;
    fr_dec    = fr_r - 32'd1;
    sr_dec    = sr_r - 2'd1;
    v1        = in_ch.data_byte;
    v4        = {in_ch.data_byte, sh_r[63:40]};
    lane_bits = v4;
    lane      = 2'd2 - bc_dec[3:2];
    vec3      = 1'b0;
    value_end = 1'b0;
    pk        = vtag_kind(v1);
    stat      = STAT_OK;

    if (acc && state_r != S_DONE && state_r != S_ERR) begin
      sh_nxt = {in_ch.data_byte, sh_r[63:8]};
      bc_nxt = bc_dec;
      if (state_r == S_SF_VLANES && bc_dec[1:0] == 2'd0) begin
        if (!vf_r[0]) lanes_nxt[lane] = lane_bits;
        else if (vf_r[1]) lanes_nxt[lane] = fp_sub(lane_bits, lanes_r[lane]);
      end
      if (bc_dec == 32'd0) begin
        unique case (state_r)
          S_TXID: begin state_nxt = S_DOC; bc_nxt = 32'd16; end
          S_DOC: begin state_nxt = S_NAME_LEN; bc_nxt = 32'd4; end
          S_NAME_LEN: begin
            if (v4 != 32'd0) begin state_nxt = S_NAME_BODY; bc_nxt = v4; end
            else begin state_nxt = S_ACTOR; bc_nxt = 32'd1; end
          end
          S_NAME_BODY: begin state_nxt = S_ACTOR; bc_nxt = 32'd1; end
          S_ACTOR: begin
            if (v1 > 8'd2) begin
              state_nxt = S_ERR; bc_nxt = 32'd0; ec_nxt = STAT_ACTOR;
            end else begin
              sr_nxt = (v1 == 8'd1) ? 2'd3 : 2'd1;
              state_nxt = S_ACTOR_LEN; bc_nxt = 32'd4;
            end
          end
          S_ACTOR_LEN: begin
            sr_nxt = sr_dec;
            if (v4 != 32'd0) begin state_nxt = S_ACTOR_BODY; bc_nxt = v4; end
            else if (sr_dec != 2'd0) begin state_nxt = S_ACTOR_LEN; bc_nxt = 32'd4; end
            else begin state_nxt = S_HASKEY; bc_nxt = 32'd1; end
          end
          S_ACTOR_BODY: begin
            if (sr_r != 2'd0) begin state_nxt = S_ACTOR_LEN; bc_nxt = 32'd4; end
            else begin state_nxt = S_HASKEY; bc_nxt = 32'd1; end
          end
          S_HASKEY: begin
            state_nxt = (v1 == 8'd1) ? S_KEY_LEN : S_OPCOUNT;
            bc_nxt = 32'd4;
          end
          S_KEY_LEN: begin
            if (v4 != 32'd0) begin state_nxt = S_KEY_BODY; bc_nxt = v4; end
            else begin state_nxt = S_OPCOUNT; bc_nxt = 32'd4; end
          end
          S_KEY_BODY: begin state_nxt = S_OPCOUNT; bc_nxt = 32'd4; end
          S_OPCOUNT: begin
            opst_nxt = v4;
            opsr_nxt = v4;
            if (v4 == 32'd0) begin state_nxt = S_DONE; bc_nxt = 32'd0; end
            else begin state_nxt = S_OPTAG; bc_nxt = 32'd1; end
          end
          S_OPTAG: begin
            case (v1) inside
              OP_SET: begin state_nxt = S_SF_NODE; bc_nxt = 32'd8; end
              OP_COMP_ADD, OP_COMP_DEL: begin state_nxt = S_CO_SKIP; bc_nxt = 32'd24; end
              OP_CREATE: begin state_nxt = S_CN_SKIP; bc_nxt = 32'd16; end
              OP_REPARENT: begin
                sr_nxt = 2'd2; state_nxt = S_RP_SKIP; bc_nxt = 32'd16;
              end
              default: begin state_nxt = S_ERR; bc_nxt = 32'd0; ec_nxt = STAT_UNSUP; end
            endcase
          end
          S_SF_NODE: begin nl_nxt = sh_nxt; state_nxt = S_SF_SKIP; bc_nxt = 32'd24; end
          S_SF_SKIP: begin vf_nxt = 4'd0; state_nxt = S_SF_VTAG; bc_nxt = 32'd1; end
          S_SF_VTAG: begin
            if (pk == PL_UNKNOWN) begin
              state_nxt = S_ERR; bc_nxt = 32'd0; ec_nxt = STAT_MALFORMED;
            end else if (v1 == VTAG_VEC3) begin
              state_nxt = S_SF_VLANES; bc_nxt = 32'd12;
            end else if (pk == PL_LENGTH) begin
              state_nxt = S_SF_VLEN; bc_nxt = 32'd4;
            end else if (vtag_bytes(v1) == 5'd0) begin
              value_end = 1'b1;
            end else begin
              state_nxt = S_SF_VSKIP; bc_nxt = {27'd0, vtag_bytes(v1)};
            end
          end
          S_SF_VLEN: begin
            if (v4 != 32'd0) begin state_nxt = S_SF_VSKIP; bc_nxt = v4; end
            else value_end = 1'b1;
          end
          S_SF_VSKIP: value_end = 1'b1;
          S_SF_VLANES: begin value_end = 1'b1; vec3 = 1'b1; end
          S_CO_SKIP: begin state_nxt = S_CO_COUNT; bc_nxt = 32'd4; end
          S_CO_COUNT: begin
            fr_nxt = v4;
            if (v4 != 32'd0) begin state_nxt = S_CO_FKEY; bc_nxt = 32'd8; end
            else begin
              opsr_nxt = op_dec;
              state_nxt = (op_dec == 32'd0) ? S_DONE : S_OPTAG;
              bc_nxt = (op_dec == 32'd0) ? 32'd0 : 32'd1;
            end
          end
          S_CO_FKEY: begin state_nxt = S_CO_VTAG; bc_nxt = 32'd1; end
          S_CO_VTAG, S_CO_VLEN, S_CO_VSKIP: begin
            if (state_r == S_CO_VTAG && pk == PL_UNKNOWN) begin
              state_nxt = S_ERR; bc_nxt = 32'd0; ec_nxt = STAT_MALFORMED;
            end else if (state_r == S_CO_VTAG && pk == PL_LENGTH) begin
              state_nxt = S_CO_VLEN; bc_nxt = 32'd4;
            end else if (state_r == S_CO_VTAG && vtag_bytes(v1) != 5'd0) begin
              state_nxt = S_CO_VSKIP; bc_nxt = {27'd0, vtag_bytes(v1)};
            end else if (state_r == S_CO_VLEN && v4 != 32'd0) begin
              state_nxt = S_CO_VSKIP; bc_nxt = v4;
            end else begin
              // end of one component field
              fr_nxt = fr_dec;
              if (fr_dec != 32'd0) begin state_nxt = S_CO_FKEY; bc_nxt = 32'd8; end
              else begin
                opsr_nxt = op_dec;
                state_nxt = (op_dec == 32'd0) ? S_DONE : S_OPTAG;
                bc_nxt = (op_dec == 32'd0) ? 32'd0 : 32'd1;
              end
            end
          end
          S_CN_SKIP: begin state_nxt = S_CN_HASP; bc_nxt = 32'd1; end
          S_CN_HASP, S_CN_PSKIP: begin
            if (state_r == S_CN_HASP && v1 == 8'd1) begin
              state_nxt = S_CN_PSKIP; bc_nxt = 32'd16;
            end else begin
              opsr_nxt = op_dec;
              state_nxt = (op_dec == 32'd0) ? S_DONE : S_OPTAG;
              bc_nxt = (op_dec == 32'd0) ? 32'd0 : 32'd1;
            end
          end
          S_RP_SKIP: begin state_nxt = S_RP_HASP; bc_nxt = 32'd1; end
          S_RP_HASP, S_RP_PSKIP: begin
            if (state_r == S_RP_HASP) sr_nxt = sr_dec;
            if (state_r == S_RP_HASP && v1 == 8'd1) begin
              state_nxt = S_RP_PSKIP; bc_nxt = 32'd16;
            end else if (sr_nxt != 2'd0) begin
              state_nxt = S_RP_HASP; bc_nxt = 32'd1;
            end else begin
              opsr_nxt = op_dec;
              state_nxt = (op_dec == 32'd0) ? S_DONE : S_OPTAG;
              bc_nxt = (op_dec == 32'd0) ? 32'd0 : 32'd1;
            end
          end
          default: begin state_nxt = S_ERR; bc_nxt = 32'd0; ec_nxt = STAT_MALFORMED; end
        endcase

        if (value_end) begin
          if (!vf_r[0]) begin
            vf_nxt = vf_r | {2'b00, vec3, 1'b1};
            state_nxt = S_SF_VTAG;
            bc_nxt = 32'd1;
          end else begin
            emit_d = vec3 && vf_r[1];
            opsr_nxt = op_dec;
            state_nxt = (op_dec == 32'd0) ? S_DONE : S_OPTAG;
            bc_nxt = (op_dec == 32'd0) ? 32'd0 : 32'd1;
          end
        end
      end
    end

    if (state_nxt == S_ERR) stat = ec_nxt;
    else if (state_nxt == S_DONE) stat = STAT_OK;
    else stat = STAT_MALFORMED;

    res_d.kind     = KIND_DELTA;
    res_d.node_id  = nl_r;
    res_d.delta_x  = lanes_nxt[0];
    res_d.delta_y  = lanes_nxt[1];
    res_d.delta_z  = lanes_nxt[2];
    res_d.status   = STAT_OK;
    res_d.op_count = 32'd0;

    res_s.kind     = KIND_STATUS;
    res_s.node_id  = 64'd0;
    res_s.delta_x  = 32'd0;
    res_s.delta_y  = 32'd0;
    res_s.delta_z  = 32'd0;
    res_s.status   = stat;
    res_s.op_count = (stat == STAT_OK) ? opst_nxt : 32'd0;

    if (acc && in_ch.is_last) begin
      emit_s    = 1'b1;
      state_nxt = S_TXID;
      bc_nxt    = 32'd8;
      sh_nxt    = 64'd0;
      opsr_nxt  = 32'd0;
      opst_nxt  = 32'd0;
      fr_nxt    = 32'd0;
      sr_nxt    = 2'd0;
      nl_nxt    = 64'd0;
      vf_nxt    = 4'd0;
      ec_nxt    = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TXID;
      bc_r    <= 32'd8;
      sh_r    <= 64'd0;
      opsr_r  <= 32'd0;
      opst_r  <= 32'd0;
      fr_r    <= 32'd0;
      sr_r    <= 2'd0;
      nl_r    <= 64'd0;
      vf_r    <= 4'd0;
      ec_r    <= STAT_OK;
      cnt_r   <= 3'd0;
      wp_r    <= 2'd0;
      rp_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      bc_r    <= bc_nxt;
      sh_r    <= sh_nxt;
      opsr_r  <= opsr_nxt;
      opst_r  <= opst_nxt;
      fr_r    <= fr_nxt;
      sr_r    <= sr_nxt;
      nl_r    <= nl_nxt;
      vf_r    <= vf_nxt;
      ec_r    <= ec_nxt;
      wp_r    <= wp_r + {1'b0, emit_d} + {1'b0, emit_s};
      rp_r    <= rp_r + {1'b0, pop};
      cnt_r   <= cnt_r + {2'd0, emit_d} + {2'd0, emit_s} - {2'd0, pop};
    end
  end

  // lane and queue payload: no reset
  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
    if (emit_d) q_r[wp_r] <= res_d;
    if (emit_s) q_r[emit_d ? wp_r + 2'd1 : wp_r] <= res_s;
  end

  assign out_ch.valid    = (cnt_r != 3'd0);
  assign out_ch.kind     = q_r[rp_r].kind;
  assign out_ch.node_id  = q_r[rp_r].node_id;
  assign out_ch.delta_x  = q_r[rp_r].delta_x;
  assign out_ch.delta_y  = q_r[rp_r].delta_y;
  assign out_ch.delta_z  = q_r[rp_r].delta_z;
  assign out_ch.status   = q_r[rp_r].status;
  assign out_ch.op_count = q_r[rp_r].op_count;

endmodule

/* sv/ettp_checker.sv */
`timescale 1ns / 1ps
`include "edit_transaction_translation_parser_assert.svh"
module ettp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [63:0] out_node_id,
  input logic [31:0] out_delta_x,
  input logic [1:0]  out_status,
  input logic [31:0] out_op_count
);
  import ettp_pkg::*;

  `ETTP_ASSERT_RESET(a_idle_after_reset, !out_valid, "result valid right after reset")
  `ETTP_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_node_id), "stalled beat changed")
  `ETTP_ASSERT_ALWAYS(a_delta_clean, !(out_valid && out_kind == KIND_DELTA) || (out_status == STAT_OK && out_op_count == 32'd0), "delta beat carries status fields")
  `ETTP_ASSERT_ALWAYS(a_status_clean, !(out_valid && out_kind == KIND_STATUS) || (out_node_id == 64'd0 && out_delta_x == 32'd0), "status beat carries delta fields")
  `ETTP_ASSERT_ALWAYS(a_count_on_ok, !(out_valid && out_status != STAT_OK) || out_op_count == 32'd0, "op count on failed transaction")

endmodule

bind edit_transaction_translation_parser ettp_checker u_ettp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_node_id  (out_ch.node_id),
  .out_delta_x  (out_ch.delta_x),
  .out_status   (out_ch.status),
  .out_op_count (out_ch.op_count)
);
